/* design/uvs_pkg.sv */
// Shared constants, types and functions for the UV sphere cell vertex generator.
package uvs_pkg;

   localparam int MaxSectionsDef = 256;
   localparam int PhaseBitsDef   = 16;
   localparam int CordicSteps    = 30;
   localparam int CsrIdxWidth    = 1;
   localparam int CsrDataWidth   = 16;
   localparam int SectWidth      = 9;
   localparam int RadWidth       = 16;
   localparam int RowWidth       = 7;
   localparam int ColWidth       = 8;
   localparam int CoordWidth     = 18;
   localparam int SlotWidth      = 3;
   localparam int NumSlots       = 6;

   localparam logic [CsrIdxWidth-1:0] CsrSections = 1'd0;
   localparam logic [CsrIdxWidth-1:0] CsrRadius   = 1'd1;

   localparam logic signed [33:0] CordicGain = 34'sh026DD3B6A;

   typedef logic signed [33:0] cord_type;

   function automatic logic signed [33:0] atan_turn(input int idx);
      logic signed [33:0] v;
      begin
         unique case (idx)
            0:  v = 34'sh020000000;
            1:  v = 34'sh012E4051E;
            2:  v = 34'sh009FB385B;
            3:  v = 34'sh0051111D4;
            4:  v = 34'sh0028B0D43;
            5:  v = 34'sh00145D7E1;
            6:  v = 34'sh000A2F61E;
            7:  v = 34'sh000517C55;
            8:  v = 34'sh00028BE53;
            9:  v = 34'sh000145F2F;
            10: v = 34'sh0000A2F98;
            11: v = 34'sh0000517CC;
            12: v = 34'sh000028BE6;
            13: v = 34'sh0000145F3;
            14: v = 34'sh00000A2FA;
            15: v = 34'sh00000517D;
            16: v = 34'sh0000028BE;
            17: v = 34'sh00000145F;
            18: v = 34'sh000000A30;
            19: v = 34'sh000000518;
            20: v = 34'sh00000028C;
            21: v = 34'sh000000146;
            22: v = 34'sh0000000A3;
            23: v = 34'sh000000051;
            24: v = 34'sh000000029;
            25: v = 34'sh000000014;
            26: v = 34'sh00000000A;
            27: v = 34'sh000000005;
            28: v = 34'sh000000003;
            29: v = 34'sh000000001;
            default: v = '0;
         endcase
         return v;
      end
   endfunction

endpackage

/* design/uvs_phase.sv */
// Phase generator: k/N of a turn by a restoring divider, one quotient bit per stage.
module uvs_phase #(
   parameter int PHASE_BITS = uvs_pkg::PhaseBitsDef
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  logic [uvs_pkg::SectWidth-1:0]  in_num,
   input  logic [uvs_pkg::SectWidth-1:0]  in_den,
   output logic                           out_valid,
   output logic [31:0]                    out_turn
);
   // Dividend = k*2^P + n/2; quotient is taken mod 2^P, so only the low P quotient bits matter.
   localparam int DW = uvs_pkg::SectWidth + PHASE_BITS;
   localparam int RW = uvs_pkg::SectWidth + 1;

   logic [DW-1:0]             dvd_ff   [PHASE_BITS+1];
   logic [RW-1:0]             rem_ff   [PHASE_BITS+1];
   logic [uvs_pkg::SectWidth-1:0] den_ff [PHASE_BITS+1];
   logic [PHASE_BITS-1:0]     quo_ff   [PHASE_BITS+1];
   logic                      vld_ff   [PHASE_BITS+1];

   // Stage 0: form the dividend and the high remainder (quotient bits above P are dropped).
   logic [DW-1:0] dvd0_in;
   logic [RW-1:0] rem0_in;
   always_comb begin
      logic [DW:0] full;
      full    = {1'b0, in_num, {PHASE_BITS{1'b0}}} + (DW+1)'(in_den >> 1);
      // High part full >> P can be up to n (k <= n); reduce it mod n.
      rem0_in = RW'(full >> PHASE_BITS);
      if (rem0_in >= RW'(in_den)) rem0_in = rem0_in - RW'(in_den);
      dvd0_in = full[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= PHASE_BITS; s++) vld_ff[s] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
         for (int s = 1; s <= PHASE_BITS; s++) vld_ff[s] <= vld_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dvd_ff[0] <= dvd0_in;
         rem_ff[0] <= rem0_in;
         den_ff[0] <= in_den;
         quo_ff[0] <= '0;
         for (int s = 1; s <= PHASE_BITS; s++) begin
            logic [RW-1:0] trial;
            trial = {rem_ff[s-1][RW-2:0], dvd_ff[s-1][PHASE_BITS-s]};
            den_ff[s] <= den_ff[s-1];
            dvd_ff[s] <= dvd_ff[s-1];
            if (den_ff[s-1] != '0 && trial >= RW'(den_ff[s-1])) begin
               rem_ff[s] <= trial - RW'(den_ff[s-1]);
               quo_ff[s] <= {quo_ff[s-1][PHASE_BITS-2:0], 1'b1};
            end else begin
               rem_ff[s] <= trial;
               quo_ff[s] <= {quo_ff[s-1][PHASE_BITS-2:0], 1'b0};
            end
         end
      end
   end

   assign out_valid = vld_ff[PHASE_BITS];
   assign out_turn  = {quo_ff[PHASE_BITS], {(32-PHASE_BITS){1'b0}}};

endmodule

/* design/uvs_cordic.sv */
// Pipelined 30-step CORDIC rotator giving Q30 cosine and sine of a 32-bit turn.
module uvs_cordic (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [31:0]           in_turn,
   output logic                  out_valid,
   output uvs_pkg::cord_type     out_cos,
   output uvs_pkg::cord_type     out_sin
);
   localparam int N = uvs_pkg::CordicSteps;

   uvs_pkg::cord_type x_ff [N+1];
   uvs_pkg::cord_type y_ff [N+1];
   uvs_pkg::cord_type z_ff [N+1];
   logic [1:0]        q_ff [N+1];
   logic              vld_ff [N+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= N; s++) vld_ff[s] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
         for (int s = 1; s <= N; s++) vld_ff[s] <= vld_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0] <= uvs_pkg::CordicGain;
         y_ff[0] <= '0;
         z_ff[0] <= $signed({4'b0, in_turn[29:0]});
         q_ff[0] <= in_turn[31:30];
         for (int s = 1; s <= N; s++) begin
            q_ff[s] <= q_ff[s-1];
            if (!z_ff[s-1][33]) begin
               x_ff[s] <= x_ff[s-1] - (y_ff[s-1] >>> (s-1));
               y_ff[s] <= y_ff[s-1] + (x_ff[s-1] >>> (s-1));
               z_ff[s] <= z_ff[s-1] - uvs_pkg::atan_turn(s-1);
            end else begin
               x_ff[s] <= x_ff[s-1] + (y_ff[s-1] >>> (s-1));
               y_ff[s] <= y_ff[s-1] - (x_ff[s-1] >>> (s-1));
               z_ff[s] <= z_ff[s-1] + uvs_pkg::atan_turn(s-1);
            end
         end
      end
   end

   always_comb begin
      unique case (q_ff[N])
         2'd0: begin out_cos = x_ff[N];  out_sin = y_ff[N];  end
         2'd1: begin out_cos = -y_ff[N]; out_sin = x_ff[N];  end
         2'd2: begin out_cos = -x_ff[N]; out_sin = -y_ff[N]; end
         default: begin out_cos = y_ff[N]; out_sin = -x_ff[N]; end
      endcase
   end

   assign out_valid = vld_ff[N];

endmodule

/* design/uv_sphere_cell_vertices_top.sv */
// The single result channel carries six vertex words a cell; an out-of-grid cell gives one word,
//   and the input is taken only when the sequencer is empty or emits its current cell's last word.
// The front pipeline (phase divider, CORDIC, products) takes a cell each cycle it advances.
// Reset (synchronous, active high) restores sections = 32 and radius = 1.0 and empties
// the pipeline.
module uv_sphere_cell_vertices_top #(
   parameter int MAX_SECTIONS = uvs_pkg::MaxSectionsDef,
   parameter int PHASE_BITS   = uvs_pkg::PhaseBitsDef
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write,
   input  logic [uvs_pkg::CsrIdxWidth-1:0]        csr_index,
   input  logic [uvs_pkg::CsrDataWidth-1:0]       csr_data,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [uvs_pkg::RowWidth-1:0]           req_cell_row,
   input  logic [uvs_pkg::ColWidth-1:0]           req_cell_col,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [uvs_pkg::CoordWidth-1:0]  rsp_x_coord,
   output logic signed [uvs_pkg::CoordWidth-1:0]  rsp_y_coord,
   output logic signed [uvs_pkg::CoordWidth-1:0]  rsp_z_coord,
   output logic [uvs_pkg::SlotWidth-1:0]          rsp_vertex_slot,
   output logic                                   rsp_last,
   output logic                                   rsp_bad_cell
);
   localparam int SW = uvs_pkg::SectWidth;
   localparam int CW = uvs_pkg::CoordWidth;
   // phase stages, CORDIC stages, product stage
   localparam int PL = (PHASE_BITS + 1) + (uvs_pkg::CordicSteps + 1) + 1;

   logic [SW-1:0]               sections_ff;
   logic [uvs_pkg::RadWidth-1:0] radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sections_ff <= SW'(32);
         radius_ff   <= uvs_pkg::RadWidth'(256);
      end else if (csr_write) begin
         unique case (csr_index)
            uvs_pkg::CsrSections: sections_ff <= csr_data[SW-1:0];
            uvs_pkg::CsrRadius:   radius_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Front pipeline: advances whenever the sequencer can take its output.
   logic advance;
   logic front_take;
   logic in_fire;
   logic bad_in;
   logic [SW-1:0] row_w, col_w;

   assign row_w  = SW'(req_cell_row);
   assign col_w  = SW'(req_cell_col);
   assign bad_in = (sections_ff < SW'(2)) || (32'(sections_ff) > MAX_SECTIONS) ||
                   (row_w >= (sections_ff >> 1)) || (col_w >= sections_ff);
   assign req_ready = advance;
   assign in_fire   = req_valid && req_ready;

   // Side pipe carries the bad flag along the front stages.
   logic bad_pipe_ff [PL];
   logic vld_pipe_ff [PL];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < PL; s++) vld_pipe_ff[s] <= 1'b0;
      end else if (advance) begin
         vld_pipe_ff[0] <= in_fire;
         for (int s = 1; s < PL; s++) vld_pipe_ff[s] <= vld_pipe_ff[s-1];
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         bad_pipe_ff[0] <= bad_in;
         for (int s = 1; s < PL; s++) bad_pipe_ff[s] <= bad_pipe_ff[s-1];
      end
   end

   // Four phases: col, col+1, row, row+1.
   logic [31:0] turn [4];
   logic        ph_vld [4];
   uvs_pkg::cord_type cv [4];
   uvs_pkg::cord_type sv [4];
   logic        co_vld [4];
   logic [SW-1:0] knum [4];
   assign knum[0] = col_w;
   assign knum[1] = col_w + SW'(1);
   assign knum[2] = row_w;
   assign knum[3] = row_w + SW'(1);

   for (genvar g = 0; g < 4; g++) begin : g_angle
      uvs_phase #(.PHASE_BITS(PHASE_BITS)) u_phase (
         .clock(clock), .reset(reset), .advance(advance), .in_valid(in_fire),
         .in_num(knum[g]), .in_den(sections_ff),
         .out_valid(ph_vld[g]), .out_turn(turn[g]));
      uvs_cordic u_cordic (
         .clock(clock), .reset(reset), .advance(advance), .in_valid(ph_vld[g]),
         .in_turn(turn[g]), .out_valid(co_vld[g]),
         .out_cos(cv[g]), .out_sin(sv[g]));
   end

   // Product stage: cos(a)*sin(p), sin(a)*sin(p) for both azimuths and polars; keep cos(p).
   uvs_pkg::cord_type pxy_ff [2][2][2];
   uvs_pkg::cord_type cp_ff  [2];
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int a = 0; a < 2; a++) begin
            for (int p = 0; p < 2; p++) begin
               logic signed [67:0] mx, my;
               mx = 68'(cv[a]) * 68'(sv[2+p]) + 68'sd536870912;
               my = 68'(sv[a]) * 68'(sv[2+p]) + 68'sd536870912;
               pxy_ff[a][p][0] <= 34'(mx >>> 30);
               pxy_ff[a][p][1] <= 34'(my >>> 30);
            end
         end
         cp_ff[0] <= cv[2];
         cp_ff[1] <= cv[3];
      end
   end

   // Sequencer holds one cell and walks its six vertices, or emits one word for an out-of-grid cell.
   logic              seq_vld_ff, seq_bad_ff;
   logic [2:0]        slot_ff;
   uvs_pkg::cord_type hx_ff [2][2][2];
   uvs_pkg::cord_type hc_ff [2];
   logic [15:0]       rad_ff;

   // Coordinate stage output register.
   logic              o_vld_ff;
   logic signed [CW-1:0] ox_ff, oy_ff, oz_ff;
   logic [2:0]        oslot_ff;
   logic              olast_ff, obad_ff;

   logic o_free, seq_emit, seq_done;
   assign o_free   = !o_vld_ff || rsp_ready;
   assign seq_emit = seq_vld_ff && o_free;
   assign seq_done = seq_emit && (seq_bad_ff || slot_ff == 3'd5);
   assign front_take = !seq_vld_ff || seq_done;
   assign advance  = front_take;

   logic az, po;
   always_comb begin
      unique case (slot_ff)
         3'd0: begin az = 1'b0; po = 1'b0; end
         3'd1: begin az = 1'b0; po = 1'b1; end
         3'd2: begin az = 1'b1; po = 1'b1; end
         3'd3: begin az = 1'b0; po = 1'b0; end
         3'd4: begin az = 1'b1; po = 1'b1; end
         default: begin az = 1'b1; po = 1'b0; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_vld_ff <= 1'b0;
      end else if (front_take) begin
         seq_vld_ff <= vld_pipe_ff[PL-1];
      end
   end
   always_ff @(posedge clock) begin
      if (front_take) begin
         seq_bad_ff <= bad_pipe_ff[PL-1];
         hx_ff      <= pxy_ff;
         hc_ff      <= cp_ff;
         rad_ff     <= radius_ff;
         slot_ff    <= 3'd0;
      end else if (seq_emit) begin
         slot_ff    <= slot_ff + 3'd1;
      end
   end

   function automatic logic signed [CW-1:0] to_coord(input logic [15:0] r,
                                                     input uvs_pkg::cord_type v);
      logic signed [51:0] m;
      begin
         m = $signed({36'b0, r}) * 52'(v) + 52'sd536870912;
         return CW'(m >>> 30);
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (o_free) begin
         o_vld_ff <= seq_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (seq_emit) begin
         oslot_ff <= seq_bad_ff ? 3'd0 : slot_ff;
         olast_ff <= seq_bad_ff || slot_ff == 3'd5;
         obad_ff  <= seq_bad_ff;
         if (seq_bad_ff) begin
            ox_ff <= '0; oy_ff <= '0; oz_ff <= '0;
         end else begin
            ox_ff <= to_coord(rad_ff, hx_ff[az][po][0]);
            oy_ff <= to_coord(rad_ff, hx_ff[az][po][1]);
            oz_ff <= to_coord(rad_ff, hc_ff[po]);
         end
      end
   end

   assign rsp_valid       = o_vld_ff;
   assign rsp_x_coord     = ox_ff;
   assign rsp_y_coord     = oy_ff;
   assign rsp_z_coord     = oz_ff;
   assign rsp_vertex_slot = oslot_ff;
   assign rsp_last        = olast_ff;
   assign rsp_bad_cell    = obad_ff;

endmodule

/* tb/sv/uv_sphere_vertex_checker.sv */
// Vertex checker: predicts each cell's vertex words and compares them with the block's output.
`timescale 1ns / 100ps
module uv_sphere_vertex_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write,
   input  logic [uvs_pkg::CsrIdxWidth-1:0]        csr_index,
   input  logic [uvs_pkg::CsrDataWidth-1:0]       csr_data,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic [uvs_pkg::RowWidth-1:0]           req_cell_row,
   input  logic [uvs_pkg::ColWidth-1:0]           req_cell_col,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic signed [uvs_pkg::CoordWidth-1:0]  rsp_x_coord,
   input  logic signed [uvs_pkg::CoordWidth-1:0]  rsp_y_coord,
   input  logic signed [uvs_pkg::CoordWidth-1:0]  rsp_z_coord,
   input  logic [uvs_pkg::SlotWidth-1:0]          rsp_vertex_slot,
   input  logic                                   rsp_last,
   input  logic                                   rsp_bad_cell,
   output int                                     mismatch_count,
   output int                                     vertices_pending
);
   import uvs_pkg::*;

   typedef struct packed {
      logic signed [CoordWidth-1:0] x;
      logic signed [CoordWidth-1:0] y;
      logic signed [CoordWidth-1:0] z;
      logic [SlotWidth-1:0]         slot;
      logic                         last;
      logic                         bad;
   } vertex_t;

   localparam longint ArcTurn [CordicSteps] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};
   localparam longint HalfQ30 = 64'sd1 << 29;

   vertex_t              vertex_queue[$];
   logic [SectWidth-1:0] sections_q;
   logic [RadWidth-1:0]  radius_q;

   assign vertices_pending = vertex_queue.size();

   function automatic logic [31:0] turn_phase(longint k, longint n);
      longint p;
      p = ((k << PhaseBitsDef) + n / 2) / n;
      p = p & ((64'sd1 << PhaseBitsDef) - 1);
      return 32'(p << (32 - PhaseBitsDef));
   endfunction

   task automatic rotate(input logic [31:0] t, output longint c, output longint s);
      longint x, y, z, dx, dy;
      x = CordicGain;
      y = 0;
      z = longint'(t[29:0]);
      for (int i = 0; i < CordicSteps; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ArcTurn[i];
         end else begin
            x += dx; y -= dy; z += ArcTurn[i];
         end
      end
      case (t[31:30])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endtask

   function automatic logic signed [CoordWidth-1:0] scale_q30(longint v);
      longint r;
      r = (longint'(radius_q) * v + HalfQ30) >>> 30;
      return CoordWidth'(r);
   endfunction

   task automatic predict_cell(input logic [RowWidth-1:0] row, input logic [ColWidth-1:0] col);
      longint n, ca[2], sa[2], cp[2], sp[2], prod;
      int az, po;
      vertex_t v;
      n = sections_q;
      if (n < 2 || n > MaxSectionsDef || row >= n / 2 || col >= n) begin
         v = '0;
         v.last = 1'b1;
         v.bad = 1'b1;
         vertex_queue.push_back(v);
         return;
      end
      for (int k = 0; k < 2; k++) begin
         rotate(turn_phase(col + k, n), ca[k], sa[k]);
         rotate(turn_phase(row + k, n), cp[k], sp[k]);
      end
      for (int i = 0; i < NumSlots; i++) begin
         // azimuth and polar corner of each slot in the two-triangle order
         az = (i == 2 || i == 4 || i == 5);
         po = (i == 1 || i == 2 || i == 4);
         prod = (ca[az] * sp[po] + HalfQ30) >>> 30;
         v.x = scale_q30(prod);
         prod = (sa[az] * sp[po] + HalfQ30) >>> 30;
         v.y = scale_q30(prod);
         v.z = scale_q30(cp[po]);
         v.slot = SlotWidth'(i);
         v.last = (i == NumSlots - 1);
         v.bad = 1'b0;
         vertex_queue.push_back(v);
      end
   endtask

   always @(posedge clock) begin
      vertex_t got, want;
      if (reset) begin
         sections_q <= 9'd32;
         radius_q <= 16'd256;
         vertex_queue.delete();
         mismatch_count <= 0;
      end else begin
         if (csr_write) begin
            if (csr_index == CsrSections) sections_q <= csr_data[SectWidth-1:0];
            else if (csr_index == CsrRadius) radius_q <= csr_data;
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_x_coord, rsp_y_coord, rsp_z_coord, rsp_vertex_slot,
                    rsp_last, rsp_bad_cell};
            if (vertex_queue.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected vertex word %p", got);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = vertex_queue.pop_front();
               if (got !== want) begin
                  if (mismatch_count < 10)
                     $display("vertex mismatch: expected %p got %p", want, got);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req_valid && req_ready) predict_cell(req_cell_row, req_cell_col);
      end
   end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top: clock, reset, cell stimulus, configuration phases and the verdict.
`timescale 1ns / 100ps
module tb_top;
   import uvs_pkg::*;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_write = 1'b0;
   logic [CsrIdxWidth-1:0]       csr_index = CsrSections;
   logic [CsrDataWidth-1:0]      csr_data = '0;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [RowWidth-1:0]          req_cell_row = '0;
   logic [ColWidth-1:0]          req_cell_col = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic signed [CoordWidth-1:0] rsp_x_coord, rsp_y_coord, rsp_z_coord;
   logic [SlotWidth-1:0]         rsp_vertex_slot;
   logic                         rsp_last, rsp_bad_cell;
   int                           mismatch_count, vertices_pending;
   int                           send_idle_pct = 0;
   int                           stall_pct = 0;
   int                           cycle_count = 0;
   int                           sections_now = 32;

   uv_sphere_cell_vertices_top dut (.*);
   uv_sphere_vertex_checker checker_i (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_cell(input int row, input int col);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cell_row <= RowWidth'(row);
      req_cell_col <= ColWidth'(col);
      // sample ready mid-cycle, where it holds for the coming edge
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic write_csr(input logic [CsrIdxWidth-1:0] idx, input int value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= CsrDataWidth'(value);
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CsrSections) sections_now = value & 9'h1FF;
   endtask

   // drain the block before touching the registers
   task automatic set_grid(input int sect, input int rad);
      req_valid <= 1'b0;
      @(posedge clock);
      while (vertices_pending != 0) @(posedge clock);
      write_csr(CsrSections, sect);
      write_csr(CsrRadius, rad);
   endtask

   task automatic random_cells(input int count);
      int rows;
      for (int i = 0; i < count; i++) begin
         rows = sections_now / 2;
         if ($urandom_range(99) < 85 && rows > 0 && sections_now <= MaxSectionsDef)
            send_cell($urandom_range(rows - 1), $urandom_range(sections_now - 1));
         else
            send_cell($urandom_range(127), $urandom_range(255));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // reset grid: corners, first bad row, first bad column, field maxima
      send_cell(0, 0);
      send_cell(15, 31);
      send_cell(16, 0);
      send_cell(0, 32);
      send_cell(127, 255);
      set_grid(256, 65535);
      send_cell(127, 255);
      send_cell(0, 128);
      send_cell(64, 0);
      set_grid(2, 0);
      send_cell(0, 1);
      send_cell(1, 0);
      set_grid(3, 300);
      send_cell(0, 2);
      send_cell(1, 0);
      set_grid(257, 256);
      send_cell(0, 0);
      set_grid(1, 256);
      send_cell(0, 0);
      set_grid(0, 256);
      send_cell(0, 0);
      set_grid(511, 256);
      send_cell(3, 3);

      set_grid(32, 256);
      send_idle_pct = 0;  stall_pct = 0;
      random_cells(105);
      set_grid(256, $urandom_range(65535));
      send_idle_pct = 78; stall_pct = 0;
      random_cells(105);
      set_grid($urandom_range(2, 256), 65535);
      send_idle_pct = 0;  stall_pct = 78;
      random_cells(105);
      set_grid(7, $urandom_range(65535));
      send_idle_pct = 32; stall_pct = 32;
      random_cells(60);
      set_grid($urandom_range(511), $urandom_range(65535));
      random_cells(45);

      req_valid <= 1'b0;
      @(posedge clock);
      while (vertices_pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && vertices_pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
